/* sv/cdg_pkg.sv */
package cdg_pkg;

  localparam int DENOM     = 8;
  localparam int COUNT_MAX = 1023;
  localparam int CNT_W     = 10;
  localparam int MOVE_W    = 10;
  localparam int AMT_W     = 20;
  localparam int VAL_W     = 9;
  localparam int RECIP_W   = 30;
  localparam int QSHIFT    = 29;
  localparam int STOCK_W   = $clog2(COUNT_MAX + 1);
  localparam int FILL_W    = ((STOCK_W > CNT_W) ? STOCK_W : CNT_W) + 1;
  localparam int STEP_W    = $clog2(DENOM);
  localparam int PART_W    = CNT_W + VAL_W;
  localparam int PAY_W     = STOCK_W + VAL_W;
  localparam int PROD_W    = AMT_W + RECIP_W;

  localparam logic [VAL_W-1:0] BILL_VALUE [DENOM] = '{
    9'd1, 9'd5, 9'd10, 9'd20, 9'd50, 9'd100, 9'd200, 9'd500
  };

  // ceil(2^QSHIFT / value): exact quotient for any 20-bit amount
  localparam logic [RECIP_W-1:0] BILL_RECIP [DENOM] = '{
    RECIP_W'((2**QSHIFT + 0) / 1),
    RECIP_W'((2**QSHIFT + 4) / 5),
    RECIP_W'((2**QSHIFT + 9) / 10),
    RECIP_W'((2**QSHIFT + 19) / 20),
    RECIP_W'((2**QSHIFT + 49) / 50),
    RECIP_W'((2**QSHIFT + 99) / 100),
    RECIP_W'((2**QSHIFT + 199) / 200),
    RECIP_W'((2**QSHIFT + 499) / 500)
  };

  typedef enum logic [1:0] {
    MODE_REFILL   = 2'd0,
    MODE_WITHDRAW = 2'd1,
    MODE_PAY      = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_SHORT      = 2'd2,
    ST_REFUSED    = 2'd3
  } status_t;

  typedef struct packed {
    logic clear;
    logic refill;
    logic withdraw;
    logic sum;
    logic quot;
    logic change;
  } cell_ctl_t;

endpackage

/* sv/cdg_in_if.sv */
interface cdg_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [cdg_pkg::CNT_W-1:0]  count_one;
  logic [cdg_pkg::CNT_W-1:0]  count_five;
  logic [cdg_pkg::CNT_W-1:0]  count_ten;
  logic [cdg_pkg::CNT_W-1:0]  count_twenty;
  logic [cdg_pkg::CNT_W-1:0]  count_fifty;
  logic [cdg_pkg::CNT_W-1:0]  count_hundred;
  logic [cdg_pkg::CNT_W-1:0]  count_two_hundred;
  logic [cdg_pkg::CNT_W-1:0]  count_five_hundred;
  logic [cdg_pkg::AMT_W-1:0]  price;

  modport source (
    output valid, mode, count_one, count_five, count_ten, count_twenty, count_fifty,
           count_hundred, count_two_hundred, count_five_hundred, price,
    input  ready
  );

  modport sink (
    input  valid, mode, count_one, count_five, count_ten, count_twenty, count_fifty,
           count_hundred, count_two_hundred, count_five_hundred, price,
    output ready
  );
endinterface

/* sv/cdg_out_if.sv */
interface cdg_out_if;
  logic                       valid;
  logic                       ready;
  logic [cdg_pkg::MOVE_W-1:0] moved_one;
  logic [cdg_pkg::MOVE_W-1:0] moved_five;
  logic [cdg_pkg::MOVE_W-1:0] moved_ten;
  logic [cdg_pkg::MOVE_W-1:0] moved_twenty;
  logic [cdg_pkg::MOVE_W-1:0] moved_fifty;
  logic [cdg_pkg::MOVE_W-1:0] moved_hundred;
  logic [cdg_pkg::MOVE_W-1:0] moved_two_hundred;
  logic [cdg_pkg::MOVE_W-1:0] moved_five_hundred;
  logic [1:0]                 status;
  logic [cdg_pkg::AMT_W-1:0]  remainder;

  modport source (
    output valid, moved_one, moved_five, moved_ten, moved_twenty, moved_fifty,
           moved_hundred, moved_two_hundred, moved_five_hundred, status, remainder,
    input  ready
  );

  modport sink (
    input  valid, moved_one, moved_five, moved_ten, moved_twenty, moved_fifty,
           moved_hundred, moved_two_hundred, moved_five_hundred, status, remainder,
    output ready
  );
endinterface

/* sv/cdg_cell.sv */
module cdg_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdg_pkg::cell_ctl_t            ctl,
  input  logic [cdg_pkg::VAL_W-1:0]     value,
  input  logic [cdg_pkg::RECIP_W-1:0]   recip,
  input  logic [cdg_pkg::CNT_W-1:0]     cnt,
  input  logic [cdg_pkg::AMT_W-1:0]     acc_in,
  output logic [cdg_pkg::AMT_W-1:0]     acc_out,
  input  logic [cdg_pkg::AMT_W-1:0]     rest_in,
  output logic [cdg_pkg::AMT_W-1:0]     rest_out,
  output logic [cdg_pkg::MOVE_W-1:0]    moved,
  output logic                          refused
);

  logic [cdg_pkg::STOCK_W-1:0] stock_r, stock_nxt;
  logic [cdg_pkg::MOVE_W-1:0]  moved_r, moved_nxt;
  logic                        refused_r, refused_nxt;
  logic [cdg_pkg::AMT_W-1:0]   acc_r, acc_nxt;
  logic [cdg_pkg::AMT_W-1:0]   rest_r, rest_nxt;
  logic [cdg_pkg::AMT_W-1:0]   quo_r, quo_nxt;

  logic [cdg_pkg::FILL_W-1:0]  fill;
  logic [cdg_pkg::PART_W-1:0]  part;
  logic [cdg_pkg::PROD_W-1:0]  prod;
  logic [cdg_pkg::STOCK_W-1:0] take;
  logic [cdg_pkg::PAY_W-1:0]   paid;

  always_comb begin
    fill = cdg_pkg::FILL_W'(stock_r) + cdg_pkg::FILL_W'(cnt);
    part = cdg_pkg::PART_W'(cnt) * cdg_pkg::PART_W'(value);
    prod = cdg_pkg::PROD_W'(rest_in) * cdg_pkg::PROD_W'(recip);
    take = (quo_r > cdg_pkg::AMT_W'(stock_r)) ? stock_r : quo_r[cdg_pkg::STOCK_W-1:0];
    paid = cdg_pkg::PAY_W'(take) * cdg_pkg::PAY_W'(value);

    stock_nxt   = stock_r;
    moved_nxt   = moved_r;
    refused_nxt = refused_r;
    acc_nxt     = acc_r;
    rest_nxt    = rest_r;
    quo_nxt     = quo_r;

    if (ctl.clear) begin
      moved_nxt   = '0;
      refused_nxt = 1'b0;
    end
    if (ctl.refill) begin
      if (fill > cdg_pkg::FILL_W'(cdg_pkg::COUNT_MAX)) begin
        stock_nxt = cdg_pkg::STOCK_W'(cdg_pkg::COUNT_MAX);
      end else begin
        stock_nxt = fill[cdg_pkg::STOCK_W-1:0];
      end
    end
    if (ctl.withdraw) begin
      if (cdg_pkg::FILL_W'(stock_r) > cdg_pkg::FILL_W'(cnt)) begin
        stock_nxt = stock_r - cdg_pkg::STOCK_W'(cnt);
        moved_nxt = cdg_pkg::MOVE_W'(cnt);
      end else begin
        refused_nxt = 1'b1;
      end
    end
    if (ctl.sum) begin
      acc_nxt = acc_in + cdg_pkg::AMT_W'(part);
    end
    if (ctl.quot) begin
      quo_nxt = prod[cdg_pkg::QSHIFT +: cdg_pkg::AMT_W];
    end
    if (ctl.change) begin
      stock_nxt = stock_r - take;
      moved_nxt = cdg_pkg::MOVE_W'(take);
      rest_nxt  = rest_in - cdg_pkg::AMT_W'(paid);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stock_r   <= '0;
      moved_r   <= '0;
      refused_r <= 1'b0;
    end else begin
      stock_r   <= stock_nxt;
      moved_r   <= moved_nxt;
      refused_r <= refused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rest_r <= rest_nxt;
    quo_r  <= quo_nxt;
  end

  assign acc_out  = acc_r;
  assign rest_out = rest_r;
  assign moved    = moved_r;
  assign refused  = refused_r;

endmodule

/* sv/change_dispenser_greedy.sv */
// Change dispenser with a stock of eight bill denominations (1 to 500 units).
// in_ch carries one request per transaction: a mode, eight bill counts and
// a price; out_ch returns one result per request: bills moved per
// denomination, a status code and a remainder. Both channels use
// valid/ready; a transaction completes when both are high at a clock edge.
// One request is worked at a time by a row of eight cells, one per
// denomination, each holding its own stock count. Refill and withdraw
// update all cells at once. Pay sums the offered bills through the row
// (one cell per cycle), compares against the price, then passes the change
// amount from the 500 cell down to the 1 cell, each cell doing a reciprocal
// multiply, then a deduct. A short payment ends after the compare.
// Unused mode: 3.
// The result sits in an output register; if the receiver stalls, the block
// still accepts the next request and holds its result until out_ch frees up.
// Synchronous active-low reset empties the stock and drops out_ch.valid.
module change_dispenser_greedy (
  input logic        clk,
  input logic        rst_n,
  cdg_in_if.sink     in_ch,
  cdg_out_if.source  out_ch
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_OPER = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_QUOT = 7'b0010000,
    S_CHG  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [cdg_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       short_r, short_nxt;
  logic [cdg_pkg::AMT_W-1:0]  diff_r, diff_nxt;

  cdg_pkg::mode_t            mode_r;
  logic [cdg_pkg::CNT_W-1:0] cnt_r [cdg_pkg::DENOM];
  logic [cdg_pkg::AMT_W-1:0] price_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [cdg_pkg::MOVE_W-1:0] moved_o_r [cdg_pkg::DENOM];
  cdg_pkg::status_t           status_o_r, status_nxt;
  logic [cdg_pkg::AMT_W-1:0]  rem_o_r, rem_nxt;

  logic                       in_fire;
  logic                       load;
  logic [cdg_pkg::AMT_W-1:0]  offered;

  cdg_pkg::cell_ctl_t         ctl [cdg_pkg::DENOM];
  logic [cdg_pkg::AMT_W-1:0]  acc_chain [cdg_pkg::DENOM+1];
  logic [cdg_pkg::AMT_W-1:0]  rest_chain [cdg_pkg::DENOM+1];
  logic [cdg_pkg::MOVE_W-1:0] moved_w [cdg_pkg::DENOM];
  logic [cdg_pkg::DENOM-1:0]  refused_w;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign acc_chain[0]  = '0;
  assign rest_chain[cdg_pkg::DENOM] = diff_r;
  assign offered       = acc_chain[cdg_pkg::DENOM];
  assign load          = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // per-cell controls
  always_comb begin
    for (int i = 0; i < cdg_pkg::DENOM; i++) begin
      ctl[i].clear    = in_fire;
      ctl[i].refill   = (state_r == S_OPER) && (mode_r == cdg_pkg::MODE_REFILL);
      ctl[i].withdraw = (state_r == S_OPER) && (mode_r == cdg_pkg::MODE_WITHDRAW);
      ctl[i].sum      = (state_r == S_SUM)  && (step_r == cdg_pkg::STEP_W'(i));
      ctl[i].quot     = (state_r == S_QUOT) && (step_r == cdg_pkg::STEP_W'(i));
      ctl[i].change   = (state_r == S_CHG)  && (step_r == cdg_pkg::STEP_W'(i));
    end
  end

  for (genvar g = 0; g < cdg_pkg::DENOM; g++) begin : g_cell
    cdg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[g]),
      .value    (cdg_pkg::BILL_VALUE[g]),
      .recip    (cdg_pkg::BILL_RECIP[g]),
      .cnt      (cnt_r[g]),
      .acc_in   (acc_chain[g]),
      .acc_out  (acc_chain[g+1]),
      .rest_in  (rest_chain[g+1]),
      .rest_out (rest_chain[g]),
      .moved    (moved_w[g]),
      .refused  (refused_w[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    short_nxt = short_r;
    diff_nxt  = diff_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          step_nxt = '0;
          case (cdg_pkg::mode_t'(in_ch.mode))
            cdg_pkg::MODE_REFILL, cdg_pkg::MODE_WITHDRAW: state_nxt = S_OPER;
            cdg_pkg::MODE_PAY: state_nxt = S_SUM;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_OPER: state_nxt = S_FIN;
      S_SUM: begin
        if (step_r == cdg_pkg::STEP_W'(cdg_pkg::DENOM - 1)) begin
          state_nxt = S_CMP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_CMP: begin
        if (offered < price_r) begin
          short_nxt = 1'b1;
          diff_nxt  = price_r - offered;
          state_nxt = S_FIN;
        end else begin
          short_nxt = 1'b0;
          diff_nxt  = offered - price_r;
          step_nxt  = cdg_pkg::STEP_W'(cdg_pkg::DENOM - 1);
          state_nxt = S_QUOT;
        end
      end
      S_QUOT: state_nxt = S_CHG;
      S_CHG: begin
        if (step_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r - 1'b1;
          state_nxt = S_QUOT;
        end
      end
      S_FIN: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    status_nxt = cdg_pkg::ST_DONE;
    rem_nxt    = '0;
    case (mode_r)
      cdg_pkg::MODE_WITHDRAW: begin
        if (|refused_w) begin
          status_nxt = cdg_pkg::ST_REFUSED;
        end
      end
      cdg_pkg::MODE_PAY: begin
        if (short_r) begin
          status_nxt = cdg_pkg::ST_SHORT;
          rem_nxt    = diff_r;
        end else begin
          rem_nxt = rest_chain[0];
          if (rest_chain[0] != '0) begin
            status_nxt = cdg_pkg::ST_INCOMPLETE;
          end
        end
      end
      default: begin
        status_nxt = cdg_pkg::ST_DONE;
        rem_nxt    = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      short_r     <= short_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    if (in_fire) begin
      mode_r   <= cdg_pkg::mode_t'(in_ch.mode);
      cnt_r[0] <= in_ch.count_one;
      cnt_r[1] <= in_ch.count_five;
      cnt_r[2] <= in_ch.count_ten;
      cnt_r[3] <= in_ch.count_twenty;
      cnt_r[4] <= in_ch.count_fifty;
      cnt_r[5] <= in_ch.count_hundred;
      cnt_r[6] <= in_ch.count_two_hundred;
      cnt_r[7] <= in_ch.count_five_hundred;
      price_r  <= in_ch.price;
    end
    if (load) begin
      moved_o_r  <= moved_w;
      status_o_r <= status_nxt;
      rem_o_r    <= rem_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.moved_one          = moved_o_r[0];
  assign out_ch.moved_five         = moved_o_r[1];
  assign out_ch.moved_ten          = moved_o_r[2];
  assign out_ch.moved_twenty       = moved_o_r[3];
  assign out_ch.moved_fifty        = moved_o_r[4];
  assign out_ch.moved_hundred      = moved_o_r[5];
  assign out_ch.moved_two_hundred  = moved_o_r[6];
  assign out_ch.moved_five_hundred = moved_o_r[7];
  assign out_ch.status             = status_o_r;
  assign out_ch.remainder          = rem_o_r;

endmodule
